// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; take in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CDAP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdap assertion failed");

// Next-cycle implication, checked outside reset.
`define CDAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdap assertion failed");

// Next-cycle implication that also holds across reset.
`define CDAP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("cdap assertion failed");

`endif

// ===== rtl/core/cdap_pkg.sv =====
// Package for the depth average pulse block: widths, register indexes,
// cloud record type, queue status type and back-end state type. No dependencies.
package cdap_pkg;

   localparam int DEPTH_W     = 16;
   localparam int CONF_W      = 11;
   localparam int LIMIT_W     = 8;
   localparam int SUM_W       = 32;
   localparam int COUNT_W     = 17;
   localparam int RATE_W      = 15;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;
   localparam int GAIN_W      = 9;
   localparam int PROD_W      = SUM_W + GAIN_W;
   localparam int SCALE_SHIFT = 10;
   localparam int STEP_W      = 5;

   localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [GAIN_W-1:0] RATE_GAIN = 9'd400;
   localparam logic [PROD_W-SCALE_SHIFT-1:0] RATE_OFFSET = 31'd50;

   localparam logic [CONF_W-1:0]  THRESHOLD_RESET  = 11'd410;
   localparam logic [LIMIT_W-1:0] SKIP_LIMIT_RESET = 8'd5;

   localparam logic [STEP_W-1:0] LAST_STEP = 5'd31;

   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SKIP_LIMIT = 1'd1;

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
   } cdap_cloud_type;

   typedef struct packed {
      logic full;
      logic empty;
   } cdap_queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_SCALE,
      BK_FINISH
   } cdap_back_state_type;

endpackage

// ===== rtl/core/confident_depth_average_pulse_top.sv =====
// Top level of the confident depth average pulse block.
// Depends on cdap_pkg, cdap_front, cdap_queue and cdap_back.
//
// Usage:
//   req_ channel carries one depth-cloud point per word (depth, confidence,
//   has_point, last_point). The block takes a word on a rising edge where
//   req_valid is high and req_stall is low. Points stream at one per cycle
//   while req_stall is low. Points above the confidence threshold add to a
//   saturating sum and count; last_point closes the cloud. Only every
//   (skip_limit+2)th cloud gives a word on the rsp_ channel (none while
//   skip_limit is 255): the pulse rate from the cloud's mean depth. The
//   closing point passes the queue write, the divider load, the radix-2
//   divide steps, the multiply and the output register before rsp_valid
//   rises. The back end takes one emitting cloud at a time; the queue holds
//   QUEUE_DEPTH emitting clouds so the front keeps taking points while the
//   divider works. req_stall rises only when that queue is full or in reset.
//   Reset (synchronous, active high) restores the register defaults, clears
//   the sums, the skip counter, the queue and rsp_valid; req_stall is held
//   high during reset. A stalled rsp_ word holds until taken, and the back
//   end waits with its next result while the output register is occupied.
//   csr_ writes go straight to the registers, one per enabled cycle.
module confident_depth_average_pulse_top import cdap_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [DEPTH_W-1:0]     req_depth,
   input  logic [CONF_W-1:0]      req_confidence,
   input  logic                   req_has_point,
   input  logic                   req_last_point,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [RATE_W-1:0]      rsp_pulse_rate,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic                  accept;
   logic                  push;
   logic                  pop;
   cdap_cloud_type        push_cloud;
   cdap_cloud_type        head_cloud;
   cdap_queue_status_type status;

   // hold the sender while the queue has no room or reset is high
   assign req_stall = reset || status.full;
   assign accept    = req_valid && !req_stall;

   cdap_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .depth          (req_depth),
      .confidence     (req_confidence),
      .has_point      (req_has_point),
      .last_point     (req_last_point),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .push           (push),
      .push_cloud     (push_cloud)
   );

   cdap_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cloud (push_cloud),
      .pop        (pop),
      .head_cloud (head_cloud),
      .status     (status)
   );

   cdap_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_cloud     (head_cloud),
      .status         (status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pulse_rate (rsp_pulse_rate)
   );

endmodule

// ===== rtl/core/cdap_front.sv =====
// Front end: accepts points, keeps saturating sum and count, runs the skip
// counter and pushes emitting clouds to the queue. Uses cdap_pkg.
module cdap_front import cdap_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [DEPTH_W-1:0]     depth,
   input  logic [CONF_W-1:0]      confidence,
   input  logic                   has_point,
   input  logic                   last_point,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output logic                   push,
   output cdap_cloud_type         push_cloud
);

   logic [CONF_W-1:0]  threshold_ff, threshold_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LIMIT_W-1:0] skip_ff, skip_in;

   logic               keep;
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_upd;
   logic [COUNT_W-1:0] count_upd;
   logic               emit;

   always_comb begin
      keep      = has_point && (confidence > threshold_ff);
      sum_wide  = {1'b0, sum_ff} + {{(SUM_W+1-DEPTH_W){1'b0}}, depth};
      sum_upd   = sum_ff;
      count_upd = count_ff;
      if (keep) begin
         sum_upd   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
         count_upd = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      end
      emit = skip_ff > limit_ff;
   end

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      skip_in  = skip_ff;
      if (accept) begin
         if (last_point) begin
            sum_in   = '0;
            count_in = '0;
            skip_in  = emit ? '0 : skip_ff + 1'b1;
         end else begin
            sum_in   = sum_upd;
            count_in = count_upd;
         end
      end
   end

   always_comb begin
      threshold_in = threshold_ff;
      limit_in     = limit_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_THRESHOLD:  threshold_in = csr_write_data;
            REG_SKIP_LIMIT: limit_in     = csr_write_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign push             = accept && last_point && emit;
   assign push_cloud.sum   = sum_upd;
   assign push_cloud.count = count_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         limit_ff     <= SKIP_LIMIT_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         skip_ff      <= '0;
      end else begin
         threshold_ff <= threshold_in;
         limit_ff     <= limit_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         skip_ff      <= skip_in;
      end
   end

endmodule

// ===== rtl/core/cdap_queue.sv =====
// Short queue of finished cloud totals between front and back end.
// Uses cdap_pkg for the record and status types.
module cdap_queue import cdap_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cdap_cloud_type        push_cloud,
   input  logic                  pop,
   output cdap_cloud_type        head_cloud,
   output cdap_queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cdap_cloud_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   always_comb begin
      status.full  = (fill_ff == CNT_FULL);
      status.empty = (fill_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      fill_in      = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   assign head_cloud = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cloud;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== rtl/core/cdap_back.sv =====
// Back end: radix-2 divide of sum by count, scale to a pulse rate and hold
// the result in the output register. Uses cdap_pkg.
module cdap_back import cdap_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cdap_cloud_type        head_cloud,
   input  cdap_queue_status_type status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [RATE_W-1:0]     rsp_pulse_rate
);

   cdap_back_state_type state_ff, state_in;

   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] div_ff;
   logic               zero_ff;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [PROD_W-1:0]  prod_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]  rate_ff;

   logic load, do_step, out_load;
   logic [COUNT_W:0]  shifted;
   logic              ge;
   logic [COUNT_W:0]  diff;
   logic [SUM_W-1:0]  avg;
   logic [PROD_W-SCALE_SHIFT-1:0] scaled;
   logic [PROD_W-SCALE_SHIFT-1:0] rate_wide;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:   if (!status.empty) state_in = BK_DIVIDE;
         BK_DIVIDE: if (step_ff == LAST_STEP) state_in = BK_SCALE;
         BK_SCALE:  state_in = BK_FINISH;
         BK_FINISH: if (!rsp_valid_ff || !rsp_stall) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      load     = 1'b0;
      do_step  = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         BK_IDLE:   load     = !status.empty;
         BK_DIVIDE: do_step  = 1'b1;
         BK_SCALE:  ;
         BK_FINISH: out_load = !rsp_valid_ff || !rsp_stall;
         default:   ;
      endcase
   end

   assign pop = load;

   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_W-1]};
      diff    = shifted - {1'b0, div_ff};
      ge      = (shifted >= {1'b0, div_ff});
      rem_in  = ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      quo_in  = {quo_ff[SUM_W-2:0], ge};
      step_in = step_ff + 1'b1;
      avg     = zero_ff ? '0 : quo_ff;
      scaled  = prod_ff[PROD_W-1:SCALE_SHIFT];
      rate_wide = (scaled <= RATE_OFFSET) ? '0 : scaled - RATE_OFFSET;
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quo_ff  <= head_cloud.sum;
         rem_ff  <= '0;
         div_ff  <= head_cloud.count;
         zero_ff <= (head_cloud.count == '0);
         step_ff <= '0;
      end else if (do_step) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_in;
      end
      if (state_ff == BK_SCALE) begin
         prod_ff <= avg * RATE_GAIN;
      end
      if (out_load) begin
         rate_ff <= rate_wide[RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pulse_rate = rate_ff;

endmodule

// ===== rtl/core/cdap_checker.sv =====
// Port-level checks for the depth average pulse block, bound to the top.
// Depends on cdap_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cdap_checker import cdap_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [RATE_W-1:0] rsp_pulse_rate
);

   localparam logic [RATE_W-1:0] RATE_LIMIT = 15'd25549;

   `CDAP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `CDAP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_pulse_rate))
   `CDAP_ASSERT_NOW(a_rate_range, clock, reset, rsp_valid, rsp_pulse_rate <= RATE_LIMIT)
   `CDAP_ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, !rsp_valid && (req_stall == reset))

endmodule

bind confident_depth_average_pulse_top cdap_checker u_cdap_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_pulse_rate (rsp_pulse_rate)
);
